// File: hdl/arat_pkg.sv
// Shared types and constants for the AT response acknowledge tracker.
// No dependencies; used by every module in hdl/.

package arat_pkg;

  localparam int unsigned LINE_CAP   = 256;
  localparam int unsigned RESP_CAP   = 1024;
  localparam int unsigned LINE_W     = $clog2(LINE_CAP);
  localparam int unsigned RESP_W     = $clog2(RESP_CAP);
  localparam int unsigned HIST_DEPTH = 10;
  localparam int unsigned NUM_PAT    = 4;
  localparam int unsigned POLL_W     = 12;
  localparam int unsigned ADDR_W     = 10;

  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_START = 2'd1,
    KIND_POLL  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACK_NONE  = 3'd0,
    ACK_OK    = 3'd1,
    ACK_ERROR = 3'd2,
    ACK_BUSY  = 3'd3,
    ACK_READY = 3'd4
  } ack_e;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_ERROR   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  // Line history, index 0 is the newest byte.
  typedef logic [HIST_DEPTH-1:0][7:0] hist_t;

  // Bytes that precede the final LF of each acknowledge, newest first.
  typedef logic [7:0] tail_t [HIST_DEPTH];

  localparam tail_t PAT_TAIL [NUM_PAT] = '{
    '{8'h0D, 8'h4B, 8'h4F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h0D, 8'h52, 8'h4F, 8'h52, 8'h52, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h0D, 8'h2E, 8'h2E, 8'h2E, 8'h70, 8'h20, 8'h79, 8'h73, 8'h75, 8'h62},
    '{8'h0D, 8'h79, 8'h64, 8'h61, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam int unsigned PAT_LEN [NUM_PAT] = '{3, 6, 10, 6};

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        rx_byte;
    logic [POLL_W-1:0] timeout_polls;
  } item_t;

  typedef struct packed {
    logic              store_enable;
    logic [ADDR_W-1:0] store_address;
    ack_e              line_ack;
    status_e           command_status;
    logic              resend_request;
    logic [ADDR_W-1:0] response_length;
  } res_t;

endpackage

// File: hdl/arat_line_match.sv
// Suffix compare of the line history against the four acknowledge tails.
// Depends on arat_pkg.

module arat_line_match (
  input  arat_pkg::hist_t hist_i,
  output arat_pkg::ack_e  ack_o
);

  logic [arat_pkg::NUM_PAT-1:0] hit;

  always_comb begin
    for (int p = 0; p < arat_pkg::NUM_PAT; p++) begin
      hit[p] = 1'b1;
      for (int k = 0; k < arat_pkg::HIST_DEPTH; k++) begin
        if ((k < arat_pkg::PAT_LEN[p]) && (hist_i[k] != arat_pkg::PAT_TAIL[p][k])) begin
          hit[p] = 1'b0;
        end
      end
    end
  end

  // first match wins
  always_comb begin
    priority if (hit[0]) begin
      ack_o = arat_pkg::ACK_OK;
    end else if (hit[1]) begin
      ack_o = arat_pkg::ACK_ERROR;
    end else if (hit[2]) begin
      ack_o = arat_pkg::ACK_BUSY;
    end else if (hit[3]) begin
      ack_o = arat_pkg::ACK_READY;
    end else begin
      ack_o = arat_pkg::ACK_NONE;
    end
  end

endmodule

// File: hdl/arat_tracker_core.sv
// Tracker state and per-word update: line history, counters, wait logic.
// Depends on arat_pkg and arat_line_match.

module arat_tracker_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             exec_i,
  input  arat_pkg::item_t  item_i,
  output arat_pkg::res_t   res_o
);

  arat_pkg::hist_t                     hist_q, hist_d;
  logic [arat_pkg::LINE_W-1:0]         line_cnt_q, line_cnt_d;
  logic [arat_pkg::RESP_W-1:0]         resp_cnt_q, resp_cnt_d;
  arat_pkg::ack_e                      ack_kind_q, ack_kind_d;
  logic                                ack_seen_q, ack_seen_d;
  logic                                waiting_q, waiting_d;
  logic [arat_pkg::POLL_W-1:0]         elapsed_q, elapsed_d;
  logic [arat_pkg::POLL_W-1:0]         limit_q, limit_d;

  arat_pkg::ack_e                      match_ack;
  logic                                held;
  logic [arat_pkg::POLL_W-1:0]         elapsed_inc;

  arat_line_match u_match (
    .hist_i (hist_q),
    .ack_o  (match_ack)
  );

  assign held        = line_cnt_q < arat_pkg::LINE_W'(arat_pkg::LINE_CAP - 1);
  assign elapsed_inc = elapsed_q + arat_pkg::POLL_W'(1);

  always_comb begin
    hist_d     = hist_q;
    line_cnt_d = line_cnt_q;
    resp_cnt_d = resp_cnt_q;
    ack_kind_d = ack_kind_q;
    ack_seen_d = ack_seen_q;
    waiting_d  = waiting_q;
    elapsed_d  = elapsed_q;
    limit_d    = limit_q;

    res_o                 = '0;
    res_o.line_ack        = arat_pkg::ACK_NONE;
    res_o.command_status  = arat_pkg::ST_PENDING;

    unique case (item_i.kind)
      arat_pkg::KIND_BYTE: begin
        if (held) begin
          line_cnt_d = line_cnt_q + arat_pkg::LINE_W'(1);
        end
        if (resp_cnt_q < arat_pkg::RESP_W'(arat_pkg::RESP_CAP - 1)) begin
          res_o.store_enable  = 1'b1;
          res_o.store_address = arat_pkg::ADDR_W'(resp_cnt_q);
          resp_cnt_d          = resp_cnt_q + arat_pkg::RESP_W'(1);
        end
        if (item_i.rx_byte == arat_pkg::CHAR_LF) begin
          if (held) begin
            res_o.line_ack = match_ack;
          end
          if (held && (match_ack != arat_pkg::ACK_NONE)) begin
            ack_kind_d = match_ack;
            ack_seen_d = 1'b1;
          end
          hist_d     = '0;
          line_cnt_d = '0;
        end else if (held) begin
          hist_d = {hist_q[arat_pkg::HIST_DEPTH-2:0], item_i.rx_byte};
        end
      end
      arat_pkg::KIND_START: begin
        ack_kind_d = arat_pkg::ACK_NONE;
        resp_cnt_d = '0;
        elapsed_d  = '0;
        limit_d    = item_i.timeout_polls;
        if (item_i.timeout_polls == '0) begin
          waiting_d            = 1'b0;
          res_o.command_status = arat_pkg::ST_TIMEOUT;
        end else begin
          waiting_d = 1'b1;
        end
      end
      arat_pkg::KIND_POLL: begin
        if (waiting_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= limit_q) begin
            res_o.command_status = arat_pkg::ST_TIMEOUT;
            waiting_d            = 1'b0;
          end else if (ack_seen_q) begin
            if ((ack_kind_q == arat_pkg::ACK_OK) || (ack_kind_q == arat_pkg::ACK_READY)) begin
              res_o.command_status = arat_pkg::ST_SUCCESS;
              waiting_d            = 1'b0;
            end else if (ack_kind_q == arat_pkg::ACK_ERROR) begin
              res_o.command_status = arat_pkg::ST_ERROR;
              waiting_d            = 1'b0;
            end else if (ack_kind_q == arat_pkg::ACK_BUSY) begin
              ack_seen_d           = 1'b0;
              res_o.resend_request = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_o.response_length = arat_pkg::ADDR_W'(resp_cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      line_cnt_q <= '0;
      resp_cnt_q <= '0;
      ack_kind_q <= arat_pkg::ACK_NONE;
      ack_seen_q <= 1'b0;
      waiting_q  <= 1'b0;
      elapsed_q  <= '0;
      limit_q    <= '0;
    end else if (exec_i) begin
      hist_q     <= hist_d;
      line_cnt_q <= line_cnt_d;
      resp_cnt_q <= resp_cnt_d;
      ack_kind_q <= ack_kind_d;
      ack_seen_q <= ack_seen_d;
      waiting_q  <= waiting_d;
      elapsed_q  <= elapsed_d;
      limit_q    <= limit_d;
    end
  end

endmodule

// File: hdl/at_response_ack_tracker.sv
// Top level of the AT response acknowledge tracker: input register, tracker
// core, result register. Depends on arat_pkg and arat_tracker_core.
//
//   channel | direction | handshake               | word
//   in      | sink      | in_valid_i / in_stall_o | kind, rx_byte, timeout_polls
//   out     | source    | out_valid_o / out_stall_i | one result per input word
//
// One word per cycle sustained while the output is not stalled.
// The core updates its state as a word moves from the input register to the
// result register, so each word sees the state left by the one before.
// Reset clears all tracker state and both valid flags.
// A stalled output holds the result register; the input register keeps
// taking a word while the result register is free or being drained.

module at_response_ack_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [11:0] timeout_polls_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        store_enable_o,
  output logic [9:0]  store_address_o,
  output logic [2:0]  line_ack_o,
  output logic [1:0]  command_status_o,
  output logic        resend_request_o,
  output logic [9:0]  response_length_o
);

  logic            s1_valid_q, s1_valid_d;
  arat_pkg::item_t s1_item_q;
  logic            out_valid_q, out_valid_d;
  arat_pkg::res_t  out_res_q;
  arat_pkg::res_t  core_res;
  logic            adv;
  logic            in_acc;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  arat_tracker_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (adv),
    .item_i (s1_item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= '{kind: kind_i, rx_byte: rx_byte_i, timeout_polls: timeout_polls_i};
    end
    if (adv) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign store_enable_o    = out_res_q.store_enable;
  assign store_address_o   = out_res_q.store_address;
  assign line_ack_o        = out_res_q.line_ack;
  assign command_status_o  = out_res_q.command_status;
  assign resend_request_o  = out_res_q.resend_request;
  assign response_length_o = out_res_q.response_length;

`ifndef SYNTHESIS
  a_resend_on_poll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && core_res.resend_request |-> s1_item_q.kind == arat_pkg::KIND_POLL)
    else $error("resend raised by a non-poll word");

  a_ack_on_lf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (core_res.line_ack != arat_pkg::ACK_NONE) |->
      (s1_item_q.kind == arat_pkg::KIND_BYTE) && (s1_item_q.rx_byte == arat_pkg::CHAR_LF))
    else $error("line ack without line end");

  a_addr_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !store_enable_o |-> store_address_o == '0)
    else $error("store address set without store enable");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_res_q))
    else $error("result register changed under stall");
`endif

endmodule
